### rtl/core/hacd_pkg.sv
// Package with the types, color codes and helper functions of the artifact color decoder.
package hacd_pkg;

    localparam int NumPix = 7;
    localparam logic [7:0] PaletteBit = 8'h80;

    typedef logic [2:0] color_t;

    localparam color_t C_BLACK  = 3'd0;
    localparam color_t C_WHITE  = 3'd1;
    localparam color_t C_PURPLE = 3'd2;
    localparam color_t C_BLUE   = 3'd3;
    localparam color_t C_GREEN  = 3'd4;
    localparam color_t C_RED    = 3'd5;

    typedef enum logic [1:0] {
        MODE_MONO          = 2'd0,
        MODE_STRICT_COLOR  = 2'd1,
        MODE_LAZY_INTERP   = 2'd2,
        MODE_STRICT_INTERP = 2'd3
    } mode_t;

    localparam mode_t ModeReset = MODE_STRICT_COLOR;

    typedef struct packed {
        logic [7:0] pattern_byte;
        logic       odd_column;
    } pix_in_t;

    typedef struct packed {
        color_t pixel_0;
        color_t pixel_1;
        color_t pixel_2;
        color_t pixel_3;
        color_t pixel_4;
        color_t pixel_5;
        color_t pixel_6;
    } pix_out_t;

    // Pipeline payload between stages.
    typedef struct packed {
        mode_t                    mode;
        logic                     odd_column;
        logic                     palette;
        color_t [NumPix-1:0]      px;
    } stage_t;

    function automatic color_t base_color(input logic phase, input logic palette);
        color_t c;
        if (phase) begin
            c = palette ? C_RED : C_GREEN;
        end else begin
            c = palette ? C_BLUE : C_PURPLE;
        end
        return c;
    endfunction

    function automatic logic is_colored(input color_t c);
        return (c != C_BLACK) && (c != C_WHITE);
    endfunction

    // Fills a black pixel between two lit neighbors; fallback is the base color on the right.
    function automatic color_t strict_fill(input color_t l, input color_t c, input color_t r,
                                           input color_t fallback);
        color_t res;
        res = c;
        if (c == C_BLACK && l != C_BLACK && r != C_BLACK) begin
            if (is_colored(l)) begin
                res = l;
            end else if (is_colored(r)) begin
                res = r;
            end else begin
                res = fallback;
            end
        end
        return res;
    endfunction

endpackage

### rtl/core/hires_artifact_color_decoder.sv
// Top level of the hi-res artifact color decoder: config register and three-stage pipeline.
//
//  Channel   Ports                              Beat
//  input     s_valid, s_ready, s_data           graphics byte and column parity
//  output    m_valid, m_ready, m_data           seven pixel color codes
//  config    cfg_wr_en, cfg_wr_data             color mode, written without wait
//
// Each beat passes through three register stages (base decode, odd-position pass,
// even-position pass).
// One beat is accepted per cycle as long as the output side keeps taking results.
// Each stage has its own valid bit and takes a new beat whenever it is empty or
// its contents move on, so bubbles close up during a stall and nothing is lost.
// Reset empties the pipeline and sets the color mode to strict color.
module hires_artifact_color_decoder
    import hacd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_wr_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  pix_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output pix_out_t   m_data
);

    mode_t  mode_reg;
    logic   dec_valid;
    logic   dec_ready;
    stage_t dec_data;
    logic   odd_valid;
    logic   odd_ready;
    stage_t odd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= ModeReset;
        end else if (cfg_wr_en) begin
            mode_reg <= mode_t'(cfg_wr_data);
        end
    end

    hacd_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .mode      (mode_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .out_data  (dec_data)
    );

    hacd_odd_pass u_odd_pass (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (odd_valid),
        .out_ready (odd_ready),
        .out_data  (odd_data)
    );

    hacd_even_pass u_even_pass (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (odd_valid),
        .in_ready  (odd_ready),
        .in_data   (odd_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

### rtl/core/hacd_decode.sv
// First stage: turns the lit bits of a graphics byte into base colors and white runs.
module hacd_decode
    import hacd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  mode_t   mode,
    input  logic    in_valid,
    output logic    in_ready,
    input  pix_in_t in_data,
    output logic    out_valid,
    input  logic    out_ready,
    output stage_t  out_data
);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;
    logic [NumPix+1:0] lit_pad;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        lit_pad = {1'b0, in_data.pattern_byte[NumPix-1:0], 1'b0};
        data_next.mode       = mode;
        data_next.odd_column = in_data.odd_column;
        data_next.palette    = |(in_data.pattern_byte & PaletteBit);
        for (int b = 0; b < NumPix; b++) begin
            if (!lit_pad[b+1]) begin
                data_next.px[b] = C_BLACK;
            end else if (lit_pad[b] || lit_pad[b+2]) begin
                // A lit bit next to another lit bit shows as white.
                data_next.px[b] = C_WHITE;
            end else begin
                data_next.px[b] = base_color(1'(b) ^ in_data.odd_column, data_next.palette);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/hacd_odd_pass.sv
// Second stage: mono whitening and the fill pass over the odd pixel positions.
module hacd_odd_pass
    import hacd_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   in_valid,
    output logic   in_ready,
    input  stage_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output stage_t out_data
);

    logic   valid_reg;
    stage_t data_reg;
    stage_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next = in_data;
        case (in_data.mode)
            MODE_MONO: begin
                for (int b = 0; b < NumPix; b++) begin
                    if (in_data.px[b] != C_BLACK) begin
                        data_next.px[b] = C_WHITE;
                    end
                end
            end
            MODE_LAZY_INTERP: begin
                for (int b = 1; b < NumPix - 1; b += 2) begin
                    if (in_data.px[b] == C_BLACK && in_data.px[b-1] != C_BLACK
                        && in_data.px[b+1] != C_BLACK) begin
                        data_next.px[b] = in_data.px[b-1];
                    end
                end
            end
            MODE_STRICT_INTERP: begin
                for (int b = 1; b < NumPix - 1; b += 2) begin
                    data_next.px[b] = strict_fill(in_data.px[b-1], in_data.px[b],
                        in_data.px[b+1],
                        base_color(1'(b + 1) ^ in_data.odd_column, in_data.palette));
                end
            end
            default: begin
                data_next = in_data;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### rtl/core/hacd_even_pass.sv
// Third stage: the fill pass over the even pixel positions and the output register.
module hacd_even_pass
    import hacd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  stage_t   in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output pix_out_t out_data
);

    logic                valid_reg;
    mode_t               mode_reg;
    color_t [NumPix-1:0] px_reg;
    color_t [NumPix-1:0] px_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        px_next = in_data.px;
        case (in_data.mode)
            MODE_LAZY_INTERP: begin
                // Edge pixels copy their only neighbor when it carries a color.
                if (in_data.px[0] == C_BLACK && is_colored(in_data.px[1])) begin
                    px_next[0] = in_data.px[1];
                end
                if (in_data.px[NumPix-1] == C_BLACK && is_colored(in_data.px[NumPix-2])) begin
                    px_next[NumPix-1] = in_data.px[NumPix-2];
                end
                for (int b = 2; b < NumPix - 1; b += 2) begin
                    if (in_data.px[b] == C_BLACK && is_colored(in_data.px[b-1])
                        && is_colored(in_data.px[b+1])) begin
                        px_next[b] = in_data.px[b-1];
                    end
                end
            end
            MODE_STRICT_INTERP: begin
                for (int b = 2; b < NumPix - 1; b += 2) begin
                    px_next[b] = strict_fill(in_data.px[b-1], in_data.px[b], in_data.px[b+1],
                        base_color(1'(b + 1) ^ in_data.odd_column, in_data.palette));
                end
            end
            default: begin
                px_next = in_data.px;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            px_reg   <= px_next;
            mode_reg <= in_data.mode;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = '{pixel_0: px_reg[0], pixel_1: px_reg[1], pixel_2: px_reg[2],
                         pixel_3: px_reg[3], pixel_4: px_reg[4], pixel_5: px_reg[5],
                         pixel_6: px_reg[6]};

    // Codes above red never leave the block.
    a_pixel_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (px_reg[0] <= C_RED && px_reg[1] <= C_RED && px_reg[2] <= C_RED
            && px_reg[3] <= C_RED && px_reg[4] <= C_RED && px_reg[5] <= C_RED
            && px_reg[6] <= C_RED))
        else $error("pixel code out of range");

    // Mono beats carry only black and white.
    a_mono_bw: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && mode_reg == MODE_MONO) |->
            (px_reg[0] <= C_WHITE && px_reg[1] <= C_WHITE && px_reg[2] <= C_WHITE
            && px_reg[3] <= C_WHITE && px_reg[4] <= C_WHITE && px_reg[5] <= C_WHITE
            && px_reg[6] <= C_WHITE))
        else $error("colored pixel in mono mode");

    // The stage only pushes back while it holds a beat.
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_ready |-> valid_reg)
        else $error("stage stalls while empty");

endmodule
